FILE: hw/rtl/ray_axis_rectangle_intersect_core_macros.svh
// Assertion macros for the ray/rectangle intersection core.
`ifndef RAY_AXIS_RECTANGLE_INTERSECT_CORE_MACROS_SVH
`define RAY_AXIS_RECTANGLE_INTERSECT_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RARIC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Condition that must hold on every rising edge outside reset.
`define RARIC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: assertion failed");

`endif

FILE: hw/rtl/raric_pkg.sv
// Types and constants shared by the ray/rectangle intersection core.
package raric_pkg;

  localparam int DEF_COORD_BITS = 32;

  localparam logic [1:0] PLANE_XY = 2'd0;
  localparam logic [1:0] PLANE_XZ = 2'd1;
  localparam logic [1:0] PLANE_YZ = 2'd2;

  localparam logic [1:0] REG_PLANE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_MIN    = 2'd3;

  localparam int T_BITS   = 31;
  localparam int TEX_BITS = 17;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        max_distance;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        hit_distance;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               front_face;
  } result_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
    logic [30:0]      tmax;
    logic [1:0]       sel;
    logic             front;
    logic             ok;
  } div_side_t;

  typedef struct packed {
    logic [30:0]      t;
    logic [2:0][31:0] p;
    logic             front;
  } tex_side_t;

endpackage

FILE: hw/rtl/raric_div_cell.sv
// One restoring division cell: resolves one quotient bit and passes the beat on.
module raric_div_cell #(
  parameter int W  = 32,
  parameter int NB = 31,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vin,
  input  logic [W-1:0]  rem_in,
  input  logic [W-1:0]  den_in,
  input  logic [NB-1:0] num_in,
  input  logic [NB-1:0] quo_in,
  input  logic [PW-1:0] side_in,
  output logic          vout,
  output logic [W-1:0]  rem_out,
  output logic [W-1:0]  den_out,
  output logic [NB-1:0] num_out,
  output logic [NB-1:0] quo_out,
  output logic [PW-1:0] side_out
);

  logic [W:0]   r2;
  logic [W+1:0] diff;
  logic         ge;

  assign r2   = {rem_in, num_in[NB-1]};
  assign diff = {1'b0, r2} - {2'b00, den_in};
  assign ge   = !diff[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else begin
      vout <= vin;
    end
    rem_out  <= ge ? diff[W-1:0] : r2[W-1:0];
    den_out  <= den_in;
    num_out  <= {num_in[NB-2:0], 1'b0};
    quo_out  <= {quo_in[NB-2:0], ge};
    side_out <= side_in;
  end

endmodule

FILE: hw/rtl/raric_div_chain.sv
// Row of division cells, one quotient bit per cell, one beat per cycle.
module raric_div_chain #(
  parameter int W  = 32,
  parameter int NB = 31,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vin,
  input  logic [W-1:0]  rem_in,
  input  logic [W-1:0]  den_in,
  input  logic [NB-1:0] num_in,
  input  logic [PW-1:0] side_in,
  output logic          vout,
  output logic [NB-1:0] quo_out,
  output logic [PW-1:0] side_out
);

  logic [NB:0]           v;
  logic [NB:0][W-1:0]    rem;
  logic [NB:0][W-1:0]    den;
  logic [NB:0][NB-1:0]   num;
  logic [NB:0][NB-1:0]   quo;
  logic [NB:0][PW-1:0]   side;

  assign v[0]    = vin;
  assign rem[0]  = rem_in;
  assign den[0]  = den_in;
  assign num[0]  = num_in;
  assign quo[0]  = '0;
  assign side[0] = side_in;

  for (genvar i = 0; i < NB; i++) begin : g_cell
    raric_div_cell #(.W(W), .NB(NB), .PW(PW)) u_cell (
      .clk(clk), .rst(rst),
      .vin(v[i]), .rem_in(rem[i]), .den_in(den[i]), .num_in(num[i]),
      .quo_in(quo[i]), .side_in(side[i]),
      .vout(v[i+1]), .rem_out(rem[i+1]), .den_out(den[i+1]), .num_out(num[i+1]),
      .quo_out(quo[i+1]), .side_out(side[i+1])
    );
  end

  assign vout     = v[NB];
  assign quo_out  = quo[NB];
  assign side_out = side[NB];

endmodule

FILE: hw/rtl/ray_axis_rectangle_intersect_core.sv
// Top level: ray against axis-aligned rectangle, one ray per cycle.
//
//  channel   signals                                   beat taken when
//  ray       start, busy, ray                          start && !busy
//  result    done, result                              done (one cycle)
//  config    cfg_we, cfg_index, cfg_data               cfg_we
//
// A ray is taken every cycle; busy stays low. On its way to the result a ray
// passes 31 cells of the distance divider, a multiply stage, a point-sum
// stage, 17 cells of the texture dividers and the output register.
// Synchronous reset clears all valid flags and resets the config registers.
// The receiver cannot stall; results are never held.
module ray_axis_rectangle_intersect_core #(
  parameter int COORD_BITS = raric_pkg::DEF_COORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  raric_pkg::ray_t    ray,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic               done,
  output raric_pkg::result_t result
);
  import raric_pkg::*;

  localparam int CW  = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int LAT = T_BITS + 2 + TEX_BITS + 1;

  logic [1:0]  plane_select;
  logic [30:0] rect_width;
  logic [30:0] rect_height;
  logic [15:0] min_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_select <= PLANE_XY;
      rect_width   <= 31'd65536;
      rect_height  <= 31'd65536;
      min_distance <= 16'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLANE:  plane_select <= cfg_data[1:0];
        REG_WIDTH:  rect_width   <= cfg_data;
        REG_HEIGHT: rect_height  <= cfg_data;
        REG_MIN:    min_distance <= cfg_data[15:0];
        default:    ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic signed [2:0][31:0] ov, dv;
  logic signed [31:0] on, dn;
  logic [31:0] mo, md;
  logic sel_ok, ovf, ok0;
  div_side_t d_in, d_out;
  logic d_vout;
  logic [30:0] t;

  assign ov[0] = 32'(signed'(ray.origin_x[CW-1:0]));
  assign ov[1] = 32'(signed'(ray.origin_y[CW-1:0]));
  assign ov[2] = 32'(signed'(ray.origin_z[CW-1:0]));
  assign dv[0] = 32'(signed'(ray.dir_x[CW-1:0]));
  assign dv[1] = 32'(signed'(ray.dir_y[CW-1:0]));
  assign dv[2] = 32'(signed'(ray.dir_z[CW-1:0]));

  always_comb begin
    sel_ok = 1'b1;
    case (plane_select)
      PLANE_XY: begin on = ov[2]; dn = dv[2]; end
      PLANE_XZ: begin on = ov[1]; dn = dv[1]; end
      PLANE_YZ: begin on = ov[0]; dn = dv[0]; end
      default:  begin on = '0; dn = '0; sel_ok = 1'b0; end
    endcase
  end

  assign mo  = on[31] ? (~on + 32'd1) : on;
  assign md  = dn[31] ? (~dn + 32'd1) : dn;
  assign ovf = {15'b0, mo} >= {md, 15'b0};
  assign ok0 = sel_ok && (rect_width != '0) && (rect_height != '0) && (dn != '0)
               && !((on != '0) && (on[31] == dn[31])) && !ovf;

  always_comb begin
    d_in.o     = ov;
    d_in.d     = dv;
    d_in.tmax  = ray.max_distance;
    d_in.sel   = plane_select;
    d_in.front = dn[31];
    d_in.ok    = ok0;
  end

  raric_div_chain #(.W(32), .NB(T_BITS), .PW($bits(div_side_t))) u_tdiv (
    .clk(clk), .rst(rst), .vin(start && !busy),
    .rem_in({15'b0, mo[31:15]}), .den_in(md), .num_in({mo[14:0], 16'b0}),
    .side_in(d_in), .vout(d_vout), .quo_out(t), .side_out(d_out)
  );

  logic                m_valid, m_front, m_ok;
  logic signed [63:0]  m_prod [3];
  logic [2:0][31:0]    m_o;
  logic [1:0]          m_sel;
  logic [30:0]         m_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= d_vout;
    end
    for (int k = 0; k < 3; k++) begin
      m_prod[k] <= $signed({1'b0, t}) * $signed(d_out.d[k]);
    end
    m_o     <= d_out.o;
    m_sel   <= d_out.sel;
    m_t     <= t;
    m_front <= d_out.front;
    m_ok    <= d_out.ok && (t >= {15'b0, min_distance}) && (t <= d_out.tmax);
  end

  logic               p_valid, p_front, p_ok;
  logic signed [48:0] p_pt [3];
  logic [1:0]         p_sel;
  logic [30:0]        p_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= m_valid;
    end
    for (int k = 0; k < 3; k++) begin
      p_pt[k] <= 49'(signed'(m_o[k])) + 49'(m_prod[k] >>> 16);
    end
    p_sel   <= m_sel;
    p_t     <= m_t;
    p_front <= m_front;
    p_ok    <= m_ok;
  end

  logic signed [48:0] pa, pb;
  logic signed [49:0] a2, b2, wv, hv, xa, xb;
  logic in_a, in_b;
  tex_side_t u_in, u_out;
  logic u_vout, v_vout, v_ok;
  logic [16:0] qu, qv;

  always_comb begin
    case (p_sel)
      PLANE_XY: begin pa = p_pt[0]; pb = p_pt[1]; end
      PLANE_XZ: begin pa = p_pt[0]; pb = p_pt[2]; end
      PLANE_YZ: begin pa = p_pt[1]; pb = p_pt[2]; end
      default:  begin pa = '0; pb = '0; end
    endcase
  end

  assign a2   = {pa, 1'b0};
  assign b2   = {pb, 1'b0};
  assign wv   = signed'({19'b0, rect_width});
  assign hv   = signed'({19'b0, rect_height});
  assign in_a = (a2 >= -wv) && (a2 <= wv);
  assign in_b = (b2 >= -hv) && (b2 <= hv);
  assign xa   = a2 + wv;
  assign xb   = b2 + hv;

  always_comb begin
    u_in.t     = p_t;
    u_in.p[0]  = p_pt[0][31:0];
    u_in.p[1]  = p_pt[1][31:0];
    u_in.p[2]  = p_pt[2][31:0];
    u_in.front = p_front;
  end

  raric_div_chain #(.W(32), .NB(TEX_BITS), .PW($bits(tex_side_t))) u_udiv (
    .clk(clk), .rst(rst), .vin(p_valid),
    .rem_in({1'b0, xa[31:1]}), .den_in({rect_width, 1'b0}), .num_in({xa[0], 16'b0}),
    .side_in(u_in), .vout(u_vout), .quo_out(qu), .side_out(u_out)
  );

  raric_div_chain #(.W(32), .NB(TEX_BITS), .PW(1)) u_vdiv (
    .clk(clk), .rst(rst), .vin(p_valid),
    .rem_in({1'b0, xb[31:1]}), .den_in({rect_height, 1'b0}), .num_in({xb[0], 16'b0}),
    .side_in(p_ok && in_a && in_b), .vout(v_vout), .quo_out(qv), .side_out(v_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= u_vout && v_vout;
    end
    if (v_ok) begin
      result.hit          <= 1'b1;
      result.hit_distance <= u_out.t;
      result.tex_u        <= qu;
      result.tex_v        <= qv;
      result.point_x      <= u_out.p[0];
      result.point_y      <= u_out.p[1];
      result.point_z      <= u_out.p[2];
      result.front_face   <= u_out.front;
    end else begin
      result <= '0;
    end
  end

`include "ray_axis_rectangle_intersect_core_macros.svh"

  `RARIC_ASSERT_IMPLY(a_latency, done, $past(start, LAT))
  `RARIC_ASSERT_IMPLY(a_miss_zero, done && !result.hit,
    result.hit_distance == '0 && result.point_x == '0 && !result.front_face)
  `RARIC_ASSERT_IMPLY(a_tex_range, done && result.hit,
    result.tex_u <= 17'd65536 && result.tex_v <= 17'd65536)
  `RARIC_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule

FILE: sim/tb_ray_axis_rectangle_intersect_core.sv
// Testbench for the ray/axis-aligned rectangle intersection core.
module tb_ray_axis_rectangle_intersect_core;
  timeunit 1ns;
  timeprecision 1ps;
  import raric_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ray_t ray = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_PLANE;
  logic [30:0] cfg_data = '0;
  logic done;
  result_t result;

  logic [1:0] plane_q = PLANE_XY;
  logic [30:0] width_q = 31'd65536;
  logic [30:0] height_q = 31'd65536;
  logic [15:0] min_dist_q = 16'd66;

  ray_t pending_rays[$];
  result_t expected_hits[$];
  int idle_pct = 14;
  int errors = 0;

  ray_axis_rectangle_intersect_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .ray(ray),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  always #2 clk = ~clk;

  function automatic result_t trace_ray(ray_t r);
    result_t res;
    longint o[3], d[3], p[3];
    longint t, on, dn, a2, b2, w, h;
    int n, ia, ib;
    res = '0;
    case (plane_q)
      PLANE_XY: begin n = 2; ia = 0; ib = 1; end
      PLANE_XZ: begin n = 1; ia = 0; ib = 2; end
      PLANE_YZ: begin n = 0; ia = 1; ib = 2; end
      default: return res;
    endcase
    o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
    d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
    w = longint'(width_q);
    h = longint'(height_q);
    if (w == 0 || h == 0 || d[n] == 0) return res;
    if (o[n] != 0 && ((o[n] < 0) == (d[n] < 0))) return res;
    on = o[n] < 0 ? -o[n] : o[n];
    dn = d[n] < 0 ? -d[n] : d[n];
    t = (on << 16) / dn;
    if (t < longint'(min_dist_q) || t > longint'(r.max_distance)) return res;
    for (int k = 0; k < 3; k++) p[k] = o[k] + ((t * d[k]) >>> 16);
    a2 = 2 * p[ia];
    b2 = 2 * p[ib];
    if (a2 < -w || a2 > w || b2 < -h || b2 > h) return res;
    res.hit = 1'b1;
    res.hit_distance = t[30:0];
    res.tex_u = 17'(((a2 + w) << 16) / (2 * w));
    res.tex_v = 17'(((b2 + h) << 16) / (2 * h));
    res.point_x = p[0][31:0];
    res.point_y = p[1][31:0];
    res.point_z = p[2][31:0];
    res.front_face = d[n] < 0;
    return res;
  endfunction

  function automatic ray_t pack_ray(longint o[3], longint d[3], longint tmax);
    ray_t r;
    r.origin_x = o[0][31:0]; r.origin_y = o[1][31:0]; r.origin_z = o[2][31:0];
    r.dir_x = d[0][31:0]; r.dir_y = d[1][31:0]; r.dir_z = d[2][31:0];
    r.max_distance = tmax[30:0];
    return r;
  endfunction

  function automatic ray_t aimed_ray();
    longint o[3], d[3], t, a, b, ra, rb, tmax;
    int n, ia, ib;
    case (plane_q)
      PLANE_XZ: begin n = 1; ia = 0; ib = 2; end
      PLANE_YZ: begin n = 0; ia = 1; ib = 2; end
      default: begin n = 2; ia = 0; ib = 1; end
    endcase
    for (int k = 0; k < 3; k++)
      d[k] = longint'($urandom_range(262144)) - 131072;
    if (d[n] == 0) d[n] = -65536;
    t = longint'(min_dist_q) + $urandom_range(1 << 20);
    ra = width_q > (1 << 25) ? (1 << 24) : width_q / 2;
    rb = height_q > (1 << 25) ? (1 << 24) : height_q / 2;
    a = longint'($urandom_range(32'(2 * ra))) - ra;
    b = longint'($urandom_range(32'(2 * rb))) - rb;
    o[n] = -((t * d[n]) >>> 16);
    o[ia] = a - ((t * d[ia]) >>> 16);
    o[ib] = b - ((t * d[ib]) >>> 16);
    tmax = ($urandom_range(9) == 0) ? t - 1 : t + $urandom_range(1 << 16);
    if (tmax < 0) tmax = 0;
    return pack_ray(o, d, tmax);
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r.origin_x = $urandom; r.origin_y = $urandom; r.origin_z = $urandom;
    r.dir_x = $urandom; r.dir_y = $urandom; r.dir_z = $urandom;
    r.max_distance = 31'($urandom);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_hits.push_back(trace_ray(ray));
      if ((!start || !busy) && pending_rays.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        ray <= pending_rays.pop_front();
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && done) begin
      if (expected_hits.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        exp_res = expected_hits.pop_front();
        if (result.hit !== exp_res.hit) begin
          $error("hit exp %0d got %0d", exp_res.hit, result.hit); errors++;
        end
        if (result.hit_distance !== exp_res.hit_distance) begin
          $error("hit_distance exp %0d got %0d", exp_res.hit_distance,
                 result.hit_distance); errors++;
        end
        if (result.tex_u !== exp_res.tex_u) begin
          $error("tex_u exp %0d got %0d", exp_res.tex_u, result.tex_u); errors++;
        end
        if (result.tex_v !== exp_res.tex_v) begin
          $error("tex_v exp %0d got %0d", exp_res.tex_v, result.tex_v); errors++;
        end
        if (result.point_x !== exp_res.point_x) begin
          $error("point_x exp %0d got %0d", exp_res.point_x, result.point_x); errors++;
        end
        if (result.point_y !== exp_res.point_y) begin
          $error("point_y exp %0d got %0d", exp_res.point_y, result.point_y); errors++;
        end
        if (result.point_z !== exp_res.point_z) begin
          $error("point_z exp %0d got %0d", exp_res.point_z, result.point_z); errors++;
        end
        if (result.front_face !== exp_res.front_face) begin
          $error("front_face exp %0d got %0d", exp_res.front_face,
                 result.front_face); errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_rays.size() > 0 || start || expected_hits.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_regs(logic [1:0] sel, logic [30:0] w, logic [30:0] h,
                            logic [15:0] mn);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_PLANE; cfg_data <= 31'(sel);
    @(posedge clk);
    cfg_index <= REG_WIDTH; cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT; cfg_data <= h;
    @(posedge clk);
    cfg_index <= REG_MIN; cfg_data <= 31'(mn);
    @(posedge clk);
    cfg_we <= 1'b0;
    plane_q <= sel; width_q <= w; height_q <= h; min_dist_q <= mn;
    @(posedge clk);
  endtask

  task automatic queue_random(int count);
    repeat (count)
      pending_rays.push_back($urandom_range(4) == 0 ? noise_ray() : aimed_ray());
  endtask

  initial begin
    longint o[3], d[3];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    o = '{32768, 0, 65536}; d = '{0, 0, -65536};
    pending_rays.push_back(pack_ray(o, d, 65536));
    pending_rays.push_back(pack_ray(o, d, 65535));
    o = '{-32768, -32768, -65536}; d = '{0, 0, 65536};
    pending_rays.push_back(pack_ray(o, d, 2147483647));
    o = '{32769, 0, 65536}; d = '{0, 0, -65536};
    pending_rays.push_back(pack_ray(o, d, 2147483647));
    o = '{0, 0, 66}; d = '{0, 0, -65536};
    pending_rays.push_back(pack_ray(o, d, 66));
    o = '{0, 0, 65}; d = '{0, 0, -65536};
    pending_rays.push_back(pack_ray(o, d, 100));
    o = '{0, 0, 0}; d = '{1, 1, 1};
    pending_rays.push_back(pack_ray(o, d, 100));
    o = '{0, 0, 65536}; d = '{65536, 0, 0};
    pending_rays.push_back(pack_ray(o, d, 2147483647));
    o = '{0, 0, 65536}; d = '{0, 0, 65536};
    pending_rays.push_back(pack_ray(o, d, 2147483647));
    o = '{-2147483648, -2147483648, -2147483648};
    d = '{2147483647, 2147483647, 2147483647};
    pending_rays.push_back(pack_ray(o, d, 2147483647));
    o = '{2147483647, 2147483647, 2147483647};
    d = '{-2147483648, -2147483648, -2147483648};
    pending_rays.push_back(pack_ray(o, d, 0));
    o = '{0, 0, -2147483648}; d = '{0, 0, 1};
    pending_rays.push_back(pack_ray(o, d, 2147483647));
    queue_random(80);
    drain();
    write_regs(PLANE_XZ, 31'h7FFFFFFF, 31'd1, 16'd0);
    o = '{0, 0, 0}; d = '{5, 5, 5};
    pending_rays.push_back(pack_ray(o, d, 0));
    queue_random(90);
    drain();
    write_regs(PLANE_YZ, 31'd1, 31'h7FFFFFFF, 16'hFFFF);
    idle_pct = 0;
    queue_random(100);
    drain();
    idle_pct = 14;
    write_regs(2'd3, 31'd65536, 31'd65536, 16'd66);
    queue_random(20);
    drain();
    write_regs(PLANE_XY, 31'd0, 31'd65536, 16'd66);
    queue_random(15);
    drain();
    write_regs(PLANE_XZ, 31'd65536, 31'd0, 16'd1);
    queue_random(15);
    drain();
    write_regs(PLANE_YZ, 31'd300000, 31'd20000, 16'd1000);
    queue_random(100);
    drain();
    write_regs(PLANE_XY, 31'd4000000, 31'd70000, 16'd0);
    queue_random(170);
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/raric_pkg.sv
hw/rtl/raric_div_cell.sv
hw/rtl/raric_div_chain.sv
hw/rtl/ray_axis_rectangle_intersect_core.sv
sim/tb_ray_axis_rectangle_intersect_core.sv
